// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, outside of reset.
`define ACPC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ACPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/acpc_pkg.sv -----
// Package for the activity classifier: sizes, derived widths and codes.
// Depends on nothing; the modules reach it by scoped names.
package acpc_pkg;

    localparam int WINDOW_LEN  = 30;
    localparam int SAMPLE_RATE = 54;

    localparam int NUM_REGS = 5;
    localparam int ADDR_W   = $clog2(4 * NUM_REGS);
    localparam int DATA_W   = 32;

    localparam int IDX_W  = $clog2(WINDOW_LEN);
    localparam int FILL_W = $clog2(WINDOW_LEN + 1);
    localparam int AX_W   = 16;
    localparam int SMP_W  = 3 * AX_W;
    localparam int MAG_W  = 17;
    localparam int CAD_W  = 16;
    localparam int PEAK_W = 6;

    // Window sums, centred deviations and the squared-magnitude accumulator
    localparam int SUM_W = AX_W + $clog2(WINDOW_LEN);
    localparam int DEV_W = SUM_W + 2;
    localparam int ABS_W = SUM_W + 1;
    localparam int ACC_W = 2 * ABS_W + 2;
    localparam int RES_W = ACC_W / 2;

    // Divide by WINDOW_LEN through a reciprocal; exact for roots below 2**RES_W
    localparam int DIV_S  = RES_W + $clog2(WINDOW_LEN);
    localparam int K_W    = RES_W + 2;
    localparam logic [K_W-1:0] DIV_K =
        K_W'(((64'd1 << DIV_S) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
    localparam int PROD_W = RES_W + K_W;

    localparam int THR_W = MAG_W + 6;
    localparam int GAP   = (SAMPLE_RATE / 4 < 2) ? 2 : SAMPLE_RATE / 4;
    localparam int GAP_W = $clog2(GAP + 1);
    localparam int CMP_W = 40;

    localparam int CAD_SCALE      = SAMPLE_RATE * 256;
    localparam int SWING_IDLE_MUL = 10;
    localparam int SWING_IDLE_LIM = 256;
    localparam int SWING_FB_MUL   = 100;
    localparam int SWING_FB_LIM   = 3072;
    localparam int CAD_FB_MUL     = 5;
    localparam int CAD_FB_DIV     = 4;

    typedef enum logic [2:0] {
        REG_WALK_CAD_MIN = 3'd0,
        REG_WALK_CAD_MAX = 3'd1,
        REG_RUN_CAD_MIN  = 3'd2,
        REG_WALK_SWING   = 3'd3,
        REG_RUN_SWING    = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        ACT_IDLE = 2'd0,
        ACT_WALK = 2'd1,
        ACT_RUN  = 2'd2
    } act_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM,
        S_SUMW,
        S_BRD,
        S_BDIF,
        S_BSQ,
        S_BSTART,
        S_BSQRT,
        S_BDIV,
        S_BMAG,
        S_PKSET,
        S_PK,
        S_PKW,
        S_CLASS
    } state_t;

endpackage

// ----- rtl/core/acpc_isqrt.sv -----
// Bit-pair iterative integer square root, one result bit per cycle.
// Depends on acpc_pkg for ACC_W and RES_W.
module acpc_isqrt
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [acpc_pkg::ACC_W-1:0]    operand,
    output logic                          done,
    output logic [acpc_pkg::RES_W-1:0]    root
);

    localparam int W = acpc_pkg::ACC_W;

    logic [W-1:0] v_reg;
    logic [W-1:0] res_reg;
    logic [W-1:0] bit_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [W-1:0] trial;

    assign trial = res_reg + bit_reg;
    assign done  = done_reg;
    assign root  = res_reg[acpc_pkg::RES_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && bit_reg[0];
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && bit_reg[0])
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= operand;
            res_reg <= '0;
            bit_reg <= W'(1) << (W - 2);
        end
        else if (busy_reg)
        begin
            // Try the next bit pair; keep it when the remainder allows
            if (v_reg >= trial)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule

// ----- rtl/core/activity_classifier_peak_cadence_top.sv -----
// Step-cadence activity classifier. One item is one accelerometer beat: a
// three-axis Q8.8 sample, or a failed-read marker (sample_valid low). Every
// item yields exactly one result beat. Failed reads and samples taken while
// the window is still filling return an all-zero result in the cycle after
// the input beat. Once the window of WINDOW_LEN samples is full, each sample
// starts an analysis that walks the sample memory and the magnitude memory:
// one pass sums the axes, one pass forms the centred magnitude of each
// sample through the shared iterative square root, and one pass counts
// peaks. At the default sizes (WINDOW_LEN 30, 23-bit root) the square root,
// shared by all samples of the window, sets the length of an analysing
// item, and no new input is taken until its result is loaded. The input is
// taken again once the result register is empty or its beat is being read.
// Thresholds sit on the APB port; the user must write them only while the
// block is idle, which the block itself does not enforce.
module activity_classifier_peak_cadence_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          sample_valid,
    input  logic signed [15:0]            accel_x,
    input  logic signed [15:0]            accel_y,
    input  logic signed [15:0]            accel_z,
    // Result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    activity,
    output logic                          window_full,
    output logic [5:0]                    peak_total,
    output logic [16:0]                   swing_amplitude,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [acpc_pkg::ADDR_W-1:0]   paddr,
    input  logic [acpc_pkg::DATA_W-1:0]   pwdata,
    output logic [acpc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int WIN   = acpc_pkg::WINDOW_LEN;
    localparam int IDX_W = acpc_pkg::IDX_W;
    localparam int MAG_W = acpc_pkg::MAG_W;
    localparam int CMP_W = acpc_pkg::CMP_W;
    localparam int THR_W = acpc_pkg::THR_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WIN - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [acpc_pkg::CAD_W-1:0] walk_cad_min_reg;
    logic [acpc_pkg::CAD_W-1:0] walk_cad_max_reg;
    logic [acpc_pkg::CAD_W-1:0] run_cad_min_reg;
    logic [MAG_W-1:0]           walk_swing_reg;
    logic [MAG_W-1:0]           run_swing_reg;
    logic                       cfg_we;
    acpc_pkg::reg_idx_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = acpc_pkg::reg_idx_t'(paddr[acpc_pkg::ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_cad_min_reg <= 16'd256;
            walk_cad_max_reg <= 16'd640;
            run_cad_min_reg  <= 16'd640;
            walk_swing_reg   <= 17'd307;
            run_swing_reg    <= 17'd512;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                acpc_pkg::REG_WALK_CAD_MIN: walk_cad_min_reg <= pwdata[15:0];
                acpc_pkg::REG_WALK_CAD_MAX: walk_cad_max_reg <= pwdata[15:0];
                acpc_pkg::REG_RUN_CAD_MIN:  run_cad_min_reg  <= pwdata[15:0];
                acpc_pkg::REG_WALK_SWING:   walk_swing_reg   <= pwdata[MAG_W-1:0];
                acpc_pkg::REG_RUN_SWING:    run_swing_reg    <= pwdata[MAG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            acpc_pkg::REG_WALK_CAD_MIN: prdata = 32'(walk_cad_min_reg);
            acpc_pkg::REG_WALK_CAD_MAX: prdata = 32'(walk_cad_max_reg);
            acpc_pkg::REG_RUN_CAD_MIN:  prdata = 32'(run_cad_min_reg);
            acpc_pkg::REG_WALK_SWING:   prdata = 32'(walk_swing_reg);
            acpc_pkg::REG_RUN_SWING:    prdata = 32'(run_swing_reg);
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    acpc_pkg::state_t            state_reg, state_next;
    logic [acpc_pkg::FILL_W-1:0] fill_reg;
    logic [IDX_W-1:0]            wr_ptr_reg;
    logic [IDX_W-1:0]            wr_ptr_inc;
    logic [IDX_W-1:0]            rptr_reg;
    logic [IDX_W-1:0]            rptr_inc;
    logic [IDX_W-1:0]            cnt_reg;
    logic [1:0]                  axis_reg;
    logic                        sumv_reg;
    logic                        pkv_reg;
    logic [IDX_W-1:0]            pkj_reg;
    logic                        out_valid_reg;

    logic in_fire;
    logic out_free;
    logic goes_full;
    logic smp_we;
    logic mag_we;
    logic sq_start;
    logic sq_done;
    logic res_load;

    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign goes_full = fill_reg >= acpc_pkg::FILL_W'(WIN - 1);
    assign wr_ptr_inc = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
    assign rptr_inc   = (rptr_reg == LAST_IDX) ? '0 : rptr_reg + 1'b1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            acpc_pkg::S_IDLE:
                if (in_fire && sample_valid && goes_full)
                    state_next = acpc_pkg::S_SUM;
            acpc_pkg::S_SUM:
                if (cnt_reg == LAST_IDX)
                    state_next = acpc_pkg::S_SUMW;
            acpc_pkg::S_SUMW:   state_next = acpc_pkg::S_BRD;
            acpc_pkg::S_BRD:    state_next = acpc_pkg::S_BDIF;
            acpc_pkg::S_BDIF:   state_next = acpc_pkg::S_BSQ;
            acpc_pkg::S_BSQ:
                if (axis_reg == 2'd2)
                    state_next = acpc_pkg::S_BSTART;
            acpc_pkg::S_BSTART: state_next = acpc_pkg::S_BSQRT;
            acpc_pkg::S_BSQRT:
                if (sq_done)
                    state_next = acpc_pkg::S_BDIV;
            acpc_pkg::S_BDIV:   state_next = acpc_pkg::S_BMAG;
            acpc_pkg::S_BMAG:
                state_next = (cnt_reg == LAST_IDX) ? acpc_pkg::S_PKSET : acpc_pkg::S_BRD;
            acpc_pkg::S_PKSET:  state_next = acpc_pkg::S_PK;
            acpc_pkg::S_PK:
                if (cnt_reg == LAST_IDX)
                    state_next = acpc_pkg::S_PKW;
            acpc_pkg::S_PKW:    state_next = acpc_pkg::S_CLASS;
            acpc_pkg::S_CLASS:
                if (out_free)
                    state_next = acpc_pkg::S_IDLE;
            default:            state_next = acpc_pkg::S_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready = 1'b0;
        mag_we   = 1'b0;
        sq_start = 1'b0;
        res_load = 1'b0;
        unique case (state_reg)
            acpc_pkg::S_IDLE:   in_ready = out_free;
            acpc_pkg::S_BSTART: sq_start = 1'b1;
            acpc_pkg::S_BMAG:   mag_we   = 1'b1;
            acpc_pkg::S_CLASS:  res_load = out_free;
            default: ;
        endcase
    end

    assign smp_we = in_fire && sample_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= acpc_pkg::S_IDLE;
            fill_reg   <= '0;
            wr_ptr_reg <= '0;
            rptr_reg   <= '0;
            cnt_reg    <= '0;
            axis_reg   <= '0;
            sumv_reg   <= 1'b0;
            pkv_reg    <= 1'b0;
            pkj_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sumv_reg  <= (state_reg == acpc_pkg::S_SUM);
            pkv_reg   <= (state_reg == acpc_pkg::S_PK);
            pkj_reg   <= cnt_reg;
            if (smp_we)
            begin
                // After the write, the next slot holds the oldest sample
                wr_ptr_reg <= wr_ptr_inc;
                rptr_reg   <= wr_ptr_inc;
                cnt_reg    <= '0;
                if (!fill_reg[acpc_pkg::FILL_W-1] || fill_reg < acpc_pkg::FILL_W'(WIN))
                    fill_reg <= fill_reg + 1'b1;
            end
            unique case (state_reg)
                acpc_pkg::S_SUM, acpc_pkg::S_BMAG:
                begin
                    // Advance around the ring; after a full lap it is back at the oldest
                    rptr_reg <= rptr_inc;
                    cnt_reg  <= (cnt_reg == LAST_IDX) ? '0 : cnt_reg + 1'b1;
                end
                acpc_pkg::S_PK:
                    cnt_reg <= (cnt_reg == LAST_IDX) ? '0 : cnt_reg + 1'b1;
                acpc_pkg::S_PKSET:
                    cnt_reg <= '0;
                acpc_pkg::S_BDIF:
                    axis_reg <= '0;
                acpc_pkg::S_BSQ:
                    axis_reg <= axis_reg + 1'b1;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sample memory: a ring of WINDOW_LEN beats, one read port
    // ------------------------------------------------------------------
    logic [acpc_pkg::SMP_W-1:0] smem [WIN];
    logic [acpc_pkg::SMP_W-1:0] smem_q_reg;

    always_ff @(posedge clk)
    begin
        if (smp_we)
            smem[wr_ptr_reg] <= {accel_x, accel_y, accel_z};
        smem_q_reg <= smem[rptr_reg];
    end

    // ------------------------------------------------------------------
    // Magnitude memory, in window order
    // ------------------------------------------------------------------
    logic [MAG_W-1:0] mmem [WIN];
    logic [MAG_W-1:0] mmem_q_reg;
    logic [MAG_W-1:0] mag_wdata;

    always_ff @(posedge clk)
    begin
        if (mag_we)
            mmem[cnt_reg] <= mag_wdata;
        mmem_q_reg <= mmem[cnt_reg];
    end

    // ------------------------------------------------------------------
    // Sum pass and magnitude pass
    // ------------------------------------------------------------------
    logic signed [acpc_pkg::SUM_W-1:0] sum_x_reg, sum_y_reg, sum_z_reg;
    logic [acpc_pkg::ABS_W-1:0]        dabs_reg [3];
    logic [acpc_pkg::ACC_W-1:0]        acc_reg;
    logic [acpc_pkg::RES_W-1:0]        root_reg;
    logic [acpc_pkg::RES_W-1:0]        sq_root;
    logic [acpc_pkg::PROD_W-1:0]       prod_reg;
    logic [MAG_W-1:0]                  lo_reg, hi_reg;

    logic signed [acpc_pkg::AX_W-1:0]  q_ax [3];
    logic signed [acpc_pkg::SUM_W-1:0] q_sum [3];
    logic signed [acpc_pkg::DEV_W-1:0] dev [3];
    logic [acpc_pkg::ABS_W-1:0]        dsel;
    logic [2*acpc_pkg::ABS_W-1:0]      dsq;

    assign q_ax[0]  = smem_q_reg[47:32];
    assign q_ax[1]  = smem_q_reg[31:16];
    assign q_ax[2]  = smem_q_reg[15:0];
    assign q_sum[0] = sum_x_reg;
    assign q_sum[1] = sum_y_reg;
    assign q_sum[2] = sum_z_reg;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
            dev[a] = acpc_pkg::DEV_W'(WIN) * acpc_pkg::DEV_W'(q_ax[a])
                     - acpc_pkg::DEV_W'(q_sum[a]);
    end

    assign dsel = (axis_reg == 2'd0) ? dabs_reg[0] :
                  (axis_reg == 2'd1) ? dabs_reg[1] : dabs_reg[2];
    assign dsq  = dsel * dsel;
    assign mag_wdata = prod_reg[acpc_pkg::DIV_S +: MAG_W];

    acpc_isqrt u_isqrt
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sq_start),
        .operand (acc_reg),
        .done    (sq_done),
        .root    (sq_root)
    );

    always_ff @(posedge clk)
    begin
        if (smp_we)
        begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            sum_z_reg <= '0;
        end
        else if (sumv_reg)
        begin
            sum_x_reg <= sum_x_reg + acpc_pkg::SUM_W'(q_ax[0]);
            sum_y_reg <= sum_y_reg + acpc_pkg::SUM_W'(q_ax[1]);
            sum_z_reg <= sum_z_reg + acpc_pkg::SUM_W'(q_ax[2]);
        end

        if (state_reg == acpc_pkg::S_BDIF)
        begin
            for (int a = 0; a < 3; a++)
                dabs_reg[a] <= dev[a][acpc_pkg::DEV_W-1] ?
                               acpc_pkg::ABS_W'(-dev[a]) : acpc_pkg::ABS_W'(dev[a]);
            acc_reg <= '0;
        end
        else if (state_reg == acpc_pkg::S_BSQ)
        begin
            acc_reg <= acc_reg + acpc_pkg::ACC_W'(dsq);
        end

        if (sq_done)
            root_reg <= sq_root;
        if (state_reg == acpc_pkg::S_BDIV)
            prod_reg <= acpc_pkg::PROD_W'(root_reg) * acpc_pkg::PROD_W'(acpc_pkg::DIV_K);

        if (mag_we)
        begin
            if (cnt_reg == '0 || mag_wdata < lo_reg)
                lo_reg <= mag_wdata;
            if (cnt_reg == '0 || mag_wdata > hi_reg)
                hi_reg <= mag_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Peak pass: a and b hold the two magnitudes before the arriving one
    // ------------------------------------------------------------------
    logic [MAG_W-1:0]           swing_reg;
    logic [THR_W-1:0]           thr_reg;
    logic [MAG_W-1:0]           pa_reg, pb_reg;
    logic [acpc_pkg::GAP_W-1:0] gap_reg;
    logic [acpc_pkg::PEAK_W-1:0] peaks_reg;
    logic                       gap_ok;
    logic                       is_peak;
    logic                       eval;

    assign gap_ok  = gap_reg >= acpc_pkg::GAP_W'(acpc_pkg::GAP);
    assign eval    = pkv_reg && (pkj_reg >= IDX_W'(2));
    assign is_peak = gap_ok && (THR_W'(pb_reg) * THR_W'(20) > thr_reg)
                     && (pb_reg > pa_reg) && (pb_reg > mmem_q_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == acpc_pkg::S_PKSET)
        begin
            swing_reg <= hi_reg - lo_reg;
            thr_reg   <= THR_W'(lo_reg) * THR_W'(20) + THR_W'(hi_reg - lo_reg) * THR_W'(7);
            peaks_reg <= '0;
            gap_reg   <= acpc_pkg::GAP_W'(acpc_pkg::GAP);
        end
        else if (pkv_reg)
        begin
            pa_reg <= pb_reg;
            pb_reg <= mmem_q_reg;
            if (eval)
            begin
                if (is_peak)
                begin
                    peaks_reg <= peaks_reg + 1'b1;
                    gap_reg   <= acpc_pkg::GAP_W'(1);
                end
                else if (!gap_ok)
                begin
                    gap_reg <= gap_reg + 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Classification and result register
    // ------------------------------------------------------------------
    logic [CMP_W-1:0]  cad;
    logic [CMP_W-1:0]  sw;
    logic              small_swing, run_hit, walk_hit, fb_hit;
    acpc_pkg::act_t    act;

    assign cad = CMP_W'(peaks_reg) * CMP_W'(acpc_pkg::CAD_SCALE);
    assign sw  = CMP_W'(swing_reg);
    assign small_swing = sw * CMP_W'(acpc_pkg::SWING_IDLE_MUL)
                         < CMP_W'(acpc_pkg::SWING_IDLE_LIM);
    assign run_hit  = (cad >= CMP_W'(run_cad_min_reg) * CMP_W'(WIN))
                      && (swing_reg >= run_swing_reg);
    assign walk_hit = (cad >= CMP_W'(walk_cad_min_reg) * CMP_W'(WIN))
                      && (cad <= CMP_W'(walk_cad_max_reg) * CMP_W'(WIN))
                      && (swing_reg >= walk_swing_reg);
    assign fb_hit   = (sw * CMP_W'(acpc_pkg::SWING_FB_MUL) >= CMP_W'(acpc_pkg::SWING_FB_LIM))
                      && (CMP_W'(peaks_reg) * CMP_W'(acpc_pkg::CAD_FB_MUL * acpc_pkg::SAMPLE_RATE)
                          >= CMP_W'(acpc_pkg::CAD_FB_DIV * WIN));

    always_comb
    begin
        priority if (small_swing) act = acpc_pkg::ACT_IDLE;
        else if (run_hit)         act = acpc_pkg::ACT_RUN;
        else if (walk_hit)        act = acpc_pkg::ACT_WALK;
        else if (fb_hit)          act = acpc_pkg::ACT_WALK;
        else                      act = acpc_pkg::ACT_IDLE;
    end

    logic imm_load;
    assign imm_load = in_fire && !(sample_valid && goes_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (imm_load || res_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (imm_load)
        begin
            // Failed read or window still filling: nothing analysed
            activity        <= acpc_pkg::ACT_IDLE;
            window_full     <= 1'b0;
            peak_total      <= '0;
            swing_amplitude <= '0;
        end
        else if (res_load)
        begin
            activity        <= act;
            window_full     <= 1'b1;
            peak_total      <= peaks_reg;
            swing_amplitude <= swing_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/core/acpc_checker.sv -----
// Port-level checker for the activity classifier, bound to the top level.
// Depends on assert_macros.svh and acpc_pkg.
`include "assert_macros.svh"

module acpc_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          sample_valid,
    input logic signed [15:0]            accel_x,
    input logic signed [15:0]            accel_y,
    input logic signed [15:0]            accel_z,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [1:0]                    activity,
    input logic                          window_full,
    input logic [5:0]                    peak_total,
    input logic [16:0]                   swing_amplitude,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [acpc_pkg::ADDR_W-1:0]   paddr,
    input logic [acpc_pkg::DATA_W-1:0]   pwdata,
    input logic [acpc_pkg::DATA_W-1:0]   prdata,
    input logic                          pready
);

    // A stalled result beat holds
    `ACPC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(swing_amplitude), "stalled result dropped or changed")

    // A failed read answers on the next cycle
    `ACPC_ASSERT(a_fail_quick, clk, rst_n, in_valid && in_ready && !sample_valid |=> out_valid && !window_full, "failed read gave no immediate result")

    // Unanalysed results are all zero
    `ACPC_ASSERT(a_zero_result, clk, rst_n, out_valid && !window_full |-> activity == acpc_pkg::ACT_IDLE && peak_total == 6'd0 && swing_amplitude == 17'd0, "unanalysed result not zero")

    // The configuration port never waits
    `ACPC_ASSERT_ALWAYS(a_pready, clk, pready, "pready dropped")

endmodule

bind activity_classifier_peak_cadence_top acpc_checker u_acpc_checker (.*);

// ----- dv/tb.sv -----
// Self-checking testbench for activity_classifier_peak_cadence_top.
// Predicts each result beat with an in-bench classifier; needs acpc_pkg and the top RTL.
`timescale 1ns / 100ps
`default_nettype none

module tb;

    localparam int WIN   = 30;
    localparam int RATE  = 54;
    localparam int N_RAND = 1150;
    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct packed {
        logic [1:0]  act;
        logic        full;
        logic [5:0]  peaks;
        logic [16:0] swing;
    } verdict_t;

    // Scoreboard: owns the classifier state and the queue of expected verdicts
    class activity_scoreboard;
        logic [15:0] cad_walk_lo, cad_walk_hi, cad_run_lo;
        logic [16:0] swing_walk, swing_run;
        int signed   hist [WIN][3];
        int          fill;
        logic [16:0] mags [WIN];
        verdict_t    pending [$];
        int          mismatches, checked, analysed, n_walk, n_run;

        function void clear();
            cad_walk_lo = 16'd256; cad_walk_hi = 16'd640; cad_run_lo = 16'd640;
            swing_walk = 17'd307; swing_run = 17'd512;
            fill = 0; mismatches = 0; checked = 0; analysed = 0; n_walk = 0; n_run = 0;
            pending.delete();
        endfunction

        function void set_reg(acpc_pkg::reg_idx_t idx, logic [31:0] v);
            case (idx)
                acpc_pkg::REG_WALK_CAD_MIN: cad_walk_lo = v[15:0];
                acpc_pkg::REG_WALK_CAD_MAX: cad_walk_hi = v[15:0];
                acpc_pkg::REG_RUN_CAD_MIN:  cad_run_lo  = v[15:0];
                acpc_pkg::REG_WALK_SWING:   swing_walk  = v[16:0];
                acpc_pkg::REG_RUN_SWING:    swing_run   = v[16:0];
                default: ;
            endcase
        endfunction

        function longint unsigned root(longint unsigned v);
            longint unsigned r, b;
            r = 0; b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        // Note an accepted input beat and queue the verdict it must produce
        function void note_sample(logic ok, logic signed [15:0] x, y, z);
            verdict_t       e;
            longint signed  sum [3];
            longint signed  d;
            longint unsigned acc, thr, cad;
            logic [16:0]    lo, hi, m;
            int             gap, last, n;
            e = '0;
            if (ok) begin
                if (fill >= WIN) begin
                    for (int i = 0; i < WIN - 1; i++) hist[i] = hist[i+1];
                    fill = WIN - 1;
                end
                hist[fill][0] = x; hist[fill][1] = y; hist[fill][2] = z;
                fill++;
                if (fill == WIN) begin
                    for (int a = 0; a < 3; a++) sum[a] = 0;
                    for (int i = 0; i < WIN; i++)
                        for (int a = 0; a < 3; a++) sum[a] += hist[i][a];
                    lo = 0; hi = 0;
                    for (int i = 0; i < WIN; i++) begin
                        acc = 0;
                        for (int a = 0; a < 3; a++) begin
                            d = WIN * longint'(hist[i][a]) - sum[a];
                            if (d < 0) d = -d;
                            acc += longint'(d) * longint'(d);
                        end
                        m = 17'(root(acc) / WIN);
                        mags[i] = m;
                        if (i == 0 || m < lo) lo = m;
                        if (i == 0 || m > hi) hi = m;
                    end
                    e.swing = hi - lo;
                    thr = 20 * longint'(lo) + 7 * longint'(e.swing);
                    gap = (RATE / 4 < 2) ? 2 : RATE / 4;
                    last = -gap; n = 0;
                    for (int i = 1; i < WIN - 1; i++) begin
                        if (i - last >= gap && 20 * longint'(mags[i]) > thr &&
                            mags[i] > mags[i-1] && mags[i] > mags[i+1]) begin
                            last = i; n++;
                        end
                    end
                    cad = longint'(n) * RATE * 256;
                    e.full = 1'b1;
                    e.peaks = 6'(n);
                    if (longint'(e.swing) * 10 < 256) e.act = acpc_pkg::ACT_IDLE;
                    else if (cad >= longint'(cad_run_lo) * WIN && e.swing >= swing_run)
                        e.act = acpc_pkg::ACT_RUN;
                    else if (cad >= longint'(cad_walk_lo) * WIN &&
                             cad <= longint'(cad_walk_hi) * WIN && e.swing >= swing_walk)
                        e.act = acpc_pkg::ACT_WALK;
                    else if (longint'(e.swing) * 100 >= 3072 && 5 * n * RATE >= 4 * WIN)
                        e.act = acpc_pkg::ACT_WALK;
                    else e.act = acpc_pkg::ACT_IDLE;
                    analysed++;
                    if (e.act == acpc_pkg::ACT_WALK) n_walk++;
                    if (e.act == acpc_pkg::ACT_RUN) n_run++;
                end
            end
            pending.push_back(e);
        endfunction

        // Compare a result beat with the oldest expectation
        function void check_verdict(verdict_t got);
            verdict_t e;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected result beat %p", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: beat %0d act %0d/%0d full %0d/%0d peaks %0d/%0d swing %0d/%0d",
                             checked, e.act, got.act, e.full, got.full,
                             e.peaks, got.peaks, e.swing, got.swing);
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic in_valid, in_ready, sample_valid;
    logic signed [15:0] accel_x, accel_y, accel_z;
    logic out_valid, out_ready;
    logic [1:0] activity;
    logic window_full;
    logic [5:0] peak_total;
    logic [16:0] swing_amplitude;
    logic psel, penable, pwrite, pready;
    logic [acpc_pkg::ADDR_W-1:0] paddr;
    logic [acpc_pkg::DATA_W-1:0] pwdata, prdata;

    activity_classifier_peak_cadence_top uut (.*);

    activity_scoreboard sb;
    bit     quiet_tail;   // no idling at all in the last part of the run
    int     stall_left;
    int     idle_cycles;
    int     n_beats;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sample result beats at the rising edge; stall the receiver in bursts
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_verdict('{activity, window_full, peak_total, swing_amplitude});
        if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(negedge clk)
    begin
        if (!rst_n || quiet_tail) out_ready <= 1'b1;
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 13);
            out_ready <= 1'b0;
        end
        else out_ready <= 1'b1;
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Write one register through a setup and an access cycle
    task automatic apb_write(acpc_pkg::reg_idx_t idx, logic [31:0] v);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= acpc_pkg::ADDR_W'(4 * int'(idx)); pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_reg(idx, v);
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Drive one input beat, holding it until accepted; valid drops only for a gap
    task automatic send_beat(logic ok, logic signed [15:0] x, y, z);
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_valid <= 1'b1; sample_valid <= ok;
        accel_x <= x; accel_y <= y; accel_z <= z;
        do @(posedge clk); while (!in_ready);
        sb.note_sample(ok, x, y, z);
        n_beats++;
        @(negedge clk);
    endtask

    // Drop valid, wait for every expected result, then give the analysis time to settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    // Stride-like waveform: a periodic bump on z with the given amplitude, random noise and some failed reads
    task automatic send_gait(int count, int period, int amp, int noise);
        int phase;
        logic signed [15:0] zv;
        phase = $urandom_range(0, period - 1);
        for (int i = 0; i < count; i++) begin
            zv = 16'(256 + (((i + phase) % period) < period / 2 ? amp : -amp) / 2
                     + int'($urandom_range(0, 2 * noise)) - noise);
            if ($urandom_range(0, 19) == 0)
                send_beat(1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
            else
                send_beat(1'b1, 16'(int'($urandom_range(0, 2 * noise)) - noise),
                          16'(int'($urandom_range(0, 2 * noise)) - noise), zv);
        end
    endtask

    task automatic program_thresholds(int mode);
        case (mode)
            0: begin
                apb_write(acpc_pkg::REG_WALK_CAD_MIN, 32'd0);
                apb_write(acpc_pkg::REG_WALK_CAD_MAX, 32'hFFFF);
                apb_write(acpc_pkg::REG_RUN_CAD_MIN, 32'hFFFF);
                apb_write(acpc_pkg::REG_WALK_SWING, 32'd0);
                apb_write(acpc_pkg::REG_RUN_SWING, 32'h1FFFF);
            end
            1: begin
                apb_write(acpc_pkg::REG_WALK_CAD_MIN, 32'hFFFF);
                apb_write(acpc_pkg::REG_WALK_CAD_MAX, 32'd0);
                apb_write(acpc_pkg::REG_RUN_CAD_MIN, 32'd0);
                apb_write(acpc_pkg::REG_WALK_SWING, 32'h1FFFF);
                apb_write(acpc_pkg::REG_RUN_SWING, 32'd0);
            end
            default: for (int r = 0; r < acpc_pkg::NUM_REGS; r++)
                apb_write(acpc_pkg::reg_idx_t'(r), (r < 3) ? $urandom_range(0, 1200)
                                                           : $urandom_range(0, 1500));
        endcase
    endtask

    initial
    begin
        int seg;
        sb = new();
        sb.clear();
        rst_n = 1'b0; in_valid = 1'b0; sample_valid = 1'b0;
        accel_x = '0; accel_y = '0; accel_z = '0;
        out_ready = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr = '0; pwdata = '0;
        quiet_tail = 1'b0; stall_left = 0; idle_cycles = 0; n_beats = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: failed reads during fill, axis extremes, then flat samples that fill the window
        send_beat(1'b0, 16'sh7FFF, 16'sh8000, 16'hFFFF);
        send_beat(1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_beat(1'b1, 16'sh8000, 16'sh8000, 16'sh8000);
        send_beat(1'b1, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_beat(1'b1, 16'sh8000, 16'sh7FFF, 16'sh8000);
        for (int i = 0; i < 14; i++) send_beat(1'b1, 16'sh0000, 16'sh0000, 16'sh0100);
        send_beat(1'b0, 16'sh0000, 16'sh0000, 16'sh0000);
        for (int i = 0; i < 13; i++) send_beat(1'b1, 16'sh0000, 16'sh0000, 16'sh0100);
        send_beat(1'b1, 16'sh5555, 16'shAAAA, 16'sh0001);
        drain();

        // Random: gait segments of varying pace and bursts of random beats under a series of threshold sets
        for (seg = 0; n_beats < N_RAND + 30; seg++) begin
            if (seg % 6 == 0) begin
                drain();
                program_thresholds((seg / 6) % 3);
            end
            if (n_beats > N_RAND - 150) quiet_tail = 1'b1;
            case ($urandom_range(0, 5))
                0: send_gait(40, $urandom_range(4, 30), $urandom_range(0, 60), 8);
                1: send_gait(40, $urandom_range(4, 30), $urandom_range(100, 1500), 30);
                2: send_gait(40, $urandom_range(8, 20), $urandom_range(300, 4000), 60);
                3: send_gait(40, $urandom_range(3, 12), $urandom_range(500, 2000), 20);
                4: for (int i = 0; i < 30; i++)
                       send_beat($urandom_range(0, 3) != 0, 16'($urandom),
                                 16'($urandom), 16'($urandom));
                default: send_gait(40, $urandom_range(10, 40), $urandom_range(50, 400), 5);
            endcase
        end
        drain();

        $display("Covered %0d input beats, %0d full-window analyses (%0d walking, %0d running).",
                 n_beats, sb.analysed, sb.n_walk, sb.n_run);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl/core
rtl/core/acpc_pkg.sv
rtl/core/acpc_isqrt.sv
rtl/core/activity_classifier_peak_cadence_top.sv
rtl/core/acpc_checker.sv
dv/tb.sv
